FILE: rtl/cbts_pkg.sv
// cbts_pkg: widths, constants, microcode types and program rom
// for the can bit timing search core; no dependencies
package cbts_pkg;

  localparam int CLK_W  = 27;
  localparam int BAUD_W = 20;
  localparam int DIVQ_W = 4;
  localparam int TW_W   = 15;
  localparam int CNT_W  = 5;
  localparam int QD_W   = 10;
  localparam int PROD_W = 15;

  localparam logic [CLK_W-1:0] CLOCK_RATE_RST = 27'd48000000;
  localparam logic [DIVQ_W-1:0] DIV_MAX       = 4'd15;
  localparam logic [5:0]        QUANTA_MAX    = 6'd32;
  localparam logic [4:0]        SEGS_MIN      = 5'd3;
  localparam logic [4:0]        SEGS_MAX      = 5'd17;

  // program addresses
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_CHECK  = 3'd1,
    ST_DIVIDE = 3'd2,
    ST_SINIT  = 3'd3,
    ST_SEARCH = 3'd4,
    ST_HIT    = 3'd5,
    ST_EMIT   = 3'd6
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_IN_VALID,
    COND_BAUD_ZERO,
    COND_DIV_LAST,
    COND_STOP,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic in_ready;
    logic res_clear;
    logic div_init;
    logic div_step;
    logic srch_init;
    logic srch_step;
    logic res_hit;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  hold;
    ctrl_t ctrl;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic baud_zero;
    logic div_last;
    logic stop;
    logic out_free;
  } stat_t;

  function automatic ucode_t ucode_rom(input step_t addr);
    ucode_t uc;
    uc = '0;
    unique case (addr)
      ST_IDLE: begin
        uc.ctrl.in_ready = 1'b1;
        uc.cond = COND_IN_VALID; uc.target = ST_CHECK; uc.hold = 1'b1;
      end
      ST_CHECK: begin
        uc.ctrl.res_clear = 1'b1;
        uc.ctrl.div_init  = 1'b1;
        uc.cond = COND_BAUD_ZERO; uc.target = ST_EMIT; uc.hold = 1'b0;
      end
      ST_DIVIDE: begin
        uc.ctrl.div_step = 1'b1;
        uc.cond = COND_DIV_LAST; uc.target = ST_SINIT; uc.hold = 1'b1;
      end
      ST_SINIT: begin
        uc.ctrl.srch_init = 1'b1;
        uc.cond = COND_NONE; uc.target = ST_IDLE; uc.hold = 1'b0;
      end
      ST_SEARCH: begin
        uc.ctrl.srch_step = 1'b1;
        uc.cond = COND_STOP; uc.target = ST_HIT; uc.hold = 1'b1;
      end
      ST_HIT: begin
        uc.ctrl.res_hit = 1'b1;
        uc.cond = COND_NONE; uc.target = ST_IDLE; uc.hold = 1'b0;
      end
      ST_EMIT: begin
        uc.ctrl.out_load = 1'b1;
        uc.cond = COND_OUT_FREE; uc.target = ST_IDLE; uc.hold = 1'b1;
      end
      default: begin
        uc.cond = COND_ALWAYS; uc.target = ST_IDLE; uc.hold = 1'b0;
      end
    endcase
    return uc;
  endfunction

endpackage

FILE: rtl/cbts_in_if.sv
// cbts_in_if: request channel carrying the baud rate
// depends on cbts_pkg
interface cbts_in_if import cbts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BAUD_W-1:0] bit_rate;

  modport source (output valid, output bit_rate, input ready);
  modport sink   (input valid, input bit_rate, output ready);
endinterface

FILE: rtl/cbts_out_if.sv
// cbts_out_if: result channel carrying found flag, divider and timing word
// depends on cbts_pkg
interface cbts_out_if import cbts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [DIVQ_W-1:0] prescale_div;
  logic [TW_W-1:0]   timing_word;

  modport source (output valid, output found, output prescale_div,
                  output timing_word, input ready);
  modport sink   (input valid, input found, input prescale_div,
                  input timing_word, output ready);
endinterface

FILE: rtl/cbts_seq.sv
// cbts_seq: step counter, program rom lookup and jump logic
// depends on cbts_pkg
module cbts_seq import cbts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t  pc_r, pc_nxt;
  ucode_t uc;
  logic   take;

  always_comb begin
    uc = ucode_rom(pc_r);
    unique case (uc.cond)
      COND_NONE:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_IN_VALID:  take = stat.in_valid;
      COND_BAUD_ZERO: take = stat.baud_zero;
      COND_DIV_LAST:  take = stat.div_last;
      COND_STOP:      take = stat.stop;
      COND_OUT_FREE:  take = stat.out_free;
      default:        take = 1'b1;
    endcase
    if (take) begin
      pc_nxt = uc.target;
    end else if (uc.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = step_t'(pc_r + 3'd1);
    end
    ctrl = uc.ctrl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/cbts_dp.sv
// cbts_dp: clock rate register, restoring divider, search counters,
// result staging and output register; depends on cbts_pkg
module cbts_dp import cbts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  input  logic              cfg_wr_en,
  input  logic [CLK_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  input  logic [BAUD_W-1:0] in_bit_rate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [DIVQ_W-1:0] out_prescale_div,
  output logic [TW_W-1:0]   out_timing_word
);

  logic [CLK_W-1:0]  clock_rate_r;
  logic [BAUD_W-1:0] baud_r;

  // divider
  logic [BAUD_W-1:0] rem_r, rem_nxt;
  logic [CLK_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [BAUD_W:0]   rem_sh;
  logic              ge;

  // search
  logic [DIVQ_W-1:0] div_r;
  logic [5:0]        quanta_r;
  logic [4:0]        segs_r;
  logic [QD_W-1:0]   qd_r;
  logic [4:0]        dv;
  logic [PROD_W-1:0] prod;
  logic              match, last;

  // packing
  logic [3:0] rest, seg1, seg2;
  logic [1:0] sjw;
  logic [5:0] q1;
  logic [TW_W-1:0] tw;

  // staged result and output register
  logic              res_found_r;
  logic [DIVQ_W-1:0] res_div_r;
  logic [TW_W-1:0]   res_tw_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [DIVQ_W-1:0] out_div_r;
  logic [TW_W-1:0]   out_tw_r;
  logic              out_free;

  always_comb begin
    rem_sh  = {rem_r, quo_r[CLK_W-1]};
    ge      = (rem_sh >= {1'b0, baud_r});
    rem_nxt = ge ? BAUD_W'(rem_sh - {1'b0, baud_r}) : rem_sh[BAUD_W-1:0];
    quo_nxt = {quo_r[CLK_W-2:0], ge};

    dv    = {1'b0, div_r} + 5'd1;
    prod  = PROD_W'(segs_r) * PROD_W'(qd_r);
    match = (quo_r == CLK_W'(prod));
    last  = (div_r == DIV_MAX) && (quanta_r == QUANTA_MAX) && (segs_r == SEGS_MAX);

    rest = 4'(segs_r - SEGS_MIN);
    seg1 = {1'b0, rest[3:1]};
    seg2 = rest - seg1;
    sjw  = (seg1 > 4'd3) ? 2'd3 : seg1[1:0];
    q1   = quanta_r - 6'd1;
    tw   = {seg2[2:0], seg1, sjw, q1};

    out_free = !out_valid_r || out_ready;

    stat.in_valid  = in_valid;
    stat.baud_zero = (baud_r == '0);
    stat.div_last  = (cnt_r == '0);
    stat.stop      = match || last;
    stat.out_free  = out_free;
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= CLOCK_RATE_RST;
    end else if (cfg_wr_en) begin
      clock_rate_r <= cfg_wr_data;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.in_ready && in_valid) begin
      baud_r <= in_bit_rate;
    end
    if (ctrl.div_init) begin
      rem_r <= '0;
      quo_r <= clock_rate_r;
      cnt_r <= CNT_W'(CLK_W - 1);
    end else if (ctrl.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
    if (ctrl.srch_init) begin
      div_r    <= '0;
      quanta_r <= 6'd1;
      segs_r   <= SEGS_MIN;
      qd_r     <= QD_W'(1);
    end else if (ctrl.srch_step && !match && !last) begin
      if (segs_r == SEGS_MAX) begin
        segs_r <= SEGS_MIN;
        if (quanta_r == QUANTA_MAX) begin
          quanta_r <= 6'd1;
          div_r    <= div_r + 1'b1;
          qd_r     <= QD_W'(dv) + QD_W'(1);
        end else begin
          quanta_r <= quanta_r + 6'd1;
          qd_r     <= qd_r + QD_W'(dv);
        end
      end else begin
        segs_r <= segs_r + 5'd1;
      end
    end
    if (ctrl.res_clear) begin
      res_found_r <= 1'b0;
      res_div_r   <= '0;
      res_tw_r    <= '0;
    end else if (ctrl.res_hit && match) begin
      res_found_r <= 1'b1;
      res_div_r   <= div_r;
      res_tw_r    <= tw;
    end
    if (ctrl.out_load && out_free) begin
      out_found_r <= res_found_r;
      out_div_r   <= res_div_r;
      out_tw_r    <= res_tw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_prescale_div = out_div_r;
  assign out_timing_word  = out_tw_r;

endmodule

FILE: rtl/can_bit_timing_search_core.sv
// can_bit_timing_search_core: top level, microcoded search for can bit timing
// depends on cbts_pkg, cbts_in_if, cbts_out_if, cbts_seq, cbts_dp
// from input transfer to result valid: check, then straight to emit for a zero baud rate, otherwise
//   divide, search init, search (one combination per cycle, up to 7680), hit and emit
// one request at a time; emit holds until the output register is free
// reset: rst_n synchronous active low; clears step counter and output valid, clock_rate 48000000
module can_bit_timing_search_core import cbts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CLK_W-1:0] cfg_wr_data,
  cbts_in_if.sink          in_ch,
  cbts_out_if.source       out_ch
);

  // control word from the program rom and status back to the jump logic
  ctrl_t ctrl;
  stat_t stat;

  // sequencer: step counter walks the rom, jumps on datapath status
  cbts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // datapath: divider, search counters and output register
  cbts_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_ch.valid),
    .in_bit_rate      (in_ch.bit_rate),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_found        (out_ch.found),
    .out_prescale_div (out_ch.prescale_div),
    .out_timing_word  (out_ch.timing_word)
  );

  // input side is ready only while the program sits in its idle step
  assign in_ch.ready = ctrl.in_ready;

endmodule

FILE: rtl/cbts_chk.sv
// cbts_chk: port level checks for can_bit_timing_search_core
// depends on cbts_pkg; bound to the top level below
module cbts_chk import cbts_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [DIVQ_W-1:0] out_prescale_div,
  input logic [TW_W-1:0]   out_timing_word
);

  // result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one request in flight: no back to back input transfers
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a miss carries zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_prescale_div == '0 && out_timing_word == '0)
    else $error("miss with nonzero fields");

  // segment split consistent on a hit
  a_hit_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |->
      !out_timing_word[11] &&
      (({1'b0, out_timing_word[14:12]} == out_timing_word[11:8]) ||
       ({1'b0, out_timing_word[14:12]} == out_timing_word[11:8] + 4'd1)) &&
      ((out_timing_word[11:8] > 4'd2 && out_timing_word[7:6] == 2'd3) ||
       (out_timing_word[11:8] < 4'd3 &&
        {2'b0, out_timing_word[7:6]} == out_timing_word[11:8])))
    else $error("inconsistent timing word");

endmodule

bind can_bit_timing_search_core cbts_chk u_cbts_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_found        (out_ch.found),
  .out_prescale_div (out_ch.prescale_div),
  .out_timing_word  (out_ch.timing_word)
);
